FILE: rtl/core/ecr_pkg.sv
// Shared types, constants and helpers for the elevation color ramp.
`timescale 1ns / 1ps
`default_nettype none

package ecr_pkg;

    localparam int STOP_SLOTS     = 7;
    localparam int NUM_CHAN       = 3;
    localparam int ELEV_W         = 16;
    localparam int CHAN_W         = 8;
    localparam int COUNT_W        = 3;
    localparam int STOP_W         = 40;
    localparam int CFG_INDEX_W    = 4;
    localparam int NUM_W          = ELEV_W + CHAN_W;
    localparam int QUO_W          = CHAN_W;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;
    localparam int PIPE_DEPTH     = DIV_STAGES + 3;

    localparam logic [CFG_INDEX_W-1:0] REG_STOP_COUNT = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STOP_FIRST = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STOP_LAST  = 4'd7;

    localparam logic [COUNT_W-1:0] STOP_COUNT_RESET = 3'd2;
    localparam logic [STOP_W-1:0]  STOP_RESET       = 40'h0000000000;
    localparam logic [STOP_W-1:0]  STOP1_RESET      = 40'h00FFFFFFFF;

    typedef logic [STOP_W-1:0] stop_t;
    typedef logic [CHAN_W-1:0] chan_t;

    // Stage after stop selection.
    typedef struct packed {
        logic                              interp;
        logic [NUM_CHAN-1:0][CHAN_W-1:0]   base;
        logic [NUM_CHAN-1:0][CHAN_W:0]     delta;
        logic [ELEV_W-1:0]                 dx;
        logic [ELEV_W-1:0]                 span;
    } sel_t;

    // Stages of the multiply and the restoring divider.
    typedef struct packed {
        logic                              interp;
        logic [NUM_CHAN-1:0][CHAN_W-1:0]   base;
        logic [NUM_CHAN-1:0]               neg;
        logic [NUM_CHAN-1:0][NUM_W-1:0]    rem;
        logic [NUM_CHAN-1:0][QUO_W-1:0]    quo;
        logic [ELEV_W-1:0]                 span;
    } div_t;

    function automatic logic signed [ELEV_W-1:0] stop_elev(input stop_t s);
        return $signed(s[STOP_W-1:STOP_W-ELEV_W]);
    endfunction

    function automatic chan_t stop_chan(input stop_t s, input int ch);
        return s[(NUM_CHAN-ch)*CHAN_W-1 -: CHAN_W];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/elevation_color_ramp.sv
// Top level of the elevation color ramp: stop selection, multiply, divide, output.
//
//  Channel   Signals                                   Meaning
//  sample    sample_valid/sample_ready, elevation       one elevation sample per item
//  pixel     pixel_valid/pixel_ready, red/green/blue    one interpolated color per item
//  cfg       cfg_valid/cfg_ready, cfg_index, cfg_data   stop count and color stops
//
// Each item passes seven register stages: stop selection, the 16 by 8 bit products,
// four stages of a restoring divider that settle two quotient bits each, and the output.
// One item enters per cycle while the pixel output is not stalled.
// A stalled pixel freezes every stage at once; sample_ready is low while that lasts.
// Reset clears the valid bits and loads the default stops; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module elevation_color_ramp
    import ecr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   sample_valid,
    output logic                        sample_ready,
    input  wire logic [ELEV_W-1:0]      elevation,
    output logic                        pixel_valid,
    input  wire logic                   pixel_ready,
    output logic [CHAN_W-1:0]           red,
    output logic [CHAN_W-1:0]           green,
    output logic [CHAN_W-1:0]           blue,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [STOP_W-1:0]      cfg_data
);

    logic [COUNT_W-1:0]          stop_count_reg;
    stop_t                       stop_reg [STOP_SLOTS];

    logic                        advance;
    logic                        sel_valid_reg;
    sel_t                        sel_reg;
    sel_t                        sel_next;
    logic [DIV_STAGES:0]         div_valid_reg;
    div_t                        div_reg  [DIV_STAGES+1];
    div_t                        mul_next;
    div_t                        div_next [1:DIV_STAGES];
    logic                        out_valid_reg;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] out_reg;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] out_next;

    assign cfg_ready    = 1'b1;
    assign advance      = !out_valid_reg || pixel_ready;
    assign sample_ready = advance;
    assign pixel_valid  = out_valid_reg;
    assign red          = out_reg[0];
    assign green        = out_reg[1];
    assign blue         = out_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_count_reg <= STOP_COUNT_RESET;
            for (int k = 0; k < STOP_SLOTS; k++)
            begin
                stop_reg[k] <= (k == 1) ? STOP1_RESET : STOP_RESET;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_STOP_COUNT)
            begin
                stop_count_reg <= cfg_data[COUNT_W-1:0];
            end
            else if (cfg_index >= REG_STOP_FIRST && cfg_index <= REG_STOP_LAST)
            begin
                stop_reg[COUNT_W'(cfg_index - REG_STOP_FIRST)] <= cfg_data;
            end
        end
    end

    // Stop selection: the unbroken run of stops at or below the sample.
    always_comb
    begin
        logic [COUNT_W-1:0]       count;
        logic                     run;
        logic [STOP_SLOTS-1:0]    ok;
        logic [COUNT_W-1:0]       idx;
        logic [COUNT_W-1:0]       nxt;
        logic signed [ELEV_W-1:0] e0;
        logic signed [ELEV_W-1:0] e1;
        logic [ELEV_W:0]          dx_wide;
        logic [ELEV_W:0]          span_wide;
        count = (stop_count_reg == '0) ? COUNT_W'(1) : stop_count_reg;
        run   = 1'b1;
        for (int k = 0; k < STOP_SLOTS; k++)
        begin
            run   = run && (COUNT_W'(k) < count)
                        && (stop_elev(stop_reg[k]) <= $signed(elevation));
            ok[k] = run;
        end
        idx = '0;
        for (int k = 0; k < STOP_SLOTS; k++)
        begin
            if (ok[k])
            begin
                idx = COUNT_W'(k);
            end
        end
        nxt = (idx == COUNT_W'(STOP_SLOTS - 1)) ? idx : idx + COUNT_W'(1);
        sel_next.interp = ok[0] && ({1'b0, idx} + 4'd1 < {1'b0, count});
        e0        = stop_elev(stop_reg[idx]);
        e1        = stop_elev(stop_reg[nxt]);
        dx_wide   = {elevation[ELEV_W-1], elevation} - {e0[ELEV_W-1], e0};
        span_wide = {e1[ELEV_W-1], e1} - {e0[ELEV_W-1], e0};
        sel_next.dx   = dx_wide[ELEV_W-1:0];
        sel_next.span = span_wide[ELEV_W-1:0];
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            sel_next.base[ch]  = stop_chan(stop_reg[idx], ch);
            sel_next.delta[ch] = {1'b0, stop_chan(stop_reg[nxt], ch)}
                               - {1'b0, stop_chan(stop_reg[idx], ch)};
        end
    end

    // Products of the sample offset and the channel step magnitudes.
    always_comb
    begin
        logic [CHAN_W:0]   mag;
        mul_next.interp = sel_reg.interp;
        mul_next.base   = sel_reg.base;
        mul_next.span   = sel_reg.span;
        mul_next.quo    = '0;
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            mul_next.neg[ch] = sel_reg.delta[ch][CHAN_W];
            mag = sel_reg.delta[ch][CHAN_W] ? -sel_reg.delta[ch] : sel_reg.delta[ch];
            mul_next.rem[ch] = {{CHAN_W{1'b0}}, sel_reg.dx}
                             * {{ELEV_W{1'b0}}, mag[CHAN_W-1:0]};
        end
    end

    // Restoring divider, two quotient bits per stage.
    always_comb
    begin
        logic [NUM_W:0] rem_w;
        logic [NUM_W:0] trial;
        for (int st = 0; st < DIV_STAGES; st++)
        begin
            div_next[st+1] = div_reg[st];
            for (int ch = 0; ch < NUM_CHAN; ch++)
            begin
                rem_w = {1'b0, div_reg[st].rem[ch]};
                for (int j = 0; j < BITS_PER_STAGE; j++)
                begin
                    trial = {{(NUM_W+1-ELEV_W){1'b0}}, div_reg[st].span}
                            << (QUO_W - 1 - st * BITS_PER_STAGE - j);
                    if (rem_w >= trial)
                    begin
                        rem_w = rem_w - trial;
                        div_next[st+1].quo[ch][QUO_W-1-st*BITS_PER_STAGE-j] = 1'b1;
                    end
                end
                div_next[st+1].rem[ch] = rem_w[NUM_W-1:0];
            end
        end
    end

    // Floor correction for falling channels and the clamped sum, or the base alone.
    always_comb
    begin
        logic [CHAN_W+1:0] step;
        logic [CHAN_W+1:0] sum;
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            step = {2'b00, div_reg[DIV_STAGES].quo[ch]}
                 + {{(CHAN_W+1){1'b0}}, |div_reg[DIV_STAGES].rem[ch]};
            sum  = {2'b00, div_reg[DIV_STAGES].base[ch]}
                 + (div_reg[DIV_STAGES].neg[ch] ? -step : {2'b00, div_reg[DIV_STAGES].quo[ch]});
            if (!div_reg[DIV_STAGES].interp)
            begin
                out_next[ch] = div_reg[DIV_STAGES].base[ch];
            end
            else if (sum[CHAN_W+1])
            begin
                out_next[ch] = '0;
            end
            else if (sum[CHAN_W])
            begin
                out_next[ch] = '1;
            end
            else
            begin
                out_next[ch] = sum[CHAN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_valid_reg <= 1'b0;
            div_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            sel_valid_reg <= sample_valid;
            div_valid_reg <= {div_valid_reg[DIV_STAGES-1:0], sel_valid_reg};
            out_valid_reg <= div_valid_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sel_reg    <= sel_next;
            div_reg[0] <= mul_next;
            for (int st = 1; st <= DIV_STAGES; st++)
            begin
                div_reg[st] <= div_next[st];
            end
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ecr_checker.sv
// Port-level checker for the elevation color ramp and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module ecr_checker
    import ecr_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              sample_valid,
    input wire logic              sample_ready,
    input wire logic              pixel_valid,
    input wire logic              pixel_ready,
    input wire logic [CHAN_W-1:0] red,
    input wire logic [CHAN_W-1:0] green,
    input wire logic [CHAN_W-1:0] blue
);

    logic [3:0] inflight_reg;
    logic [3:0] inflight_next;

    always_comb
    begin
        inflight_next = inflight_reg
                      + {3'b000, sample_valid && sample_ready}
                      - {3'b000, pixel_valid && pixel_ready};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // A stalled pixel keeps its color.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_ready |=> pixel_valid && $stable({red, green, blue}))
        else $error("stalled pixel changed");

    // No new item is taken while the output is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_ready |-> !sample_ready)
        else $error("sample taken while pixel stalled");

    // Every pixel comes from an accepted sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid |-> inflight_reg != 4'd0)
        else $error("pixel without a sample");

    // The pipeline never holds more items than it has stages.
    assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 4'(PIPE_DEPTH))
        else $error("more items in flight than stages");

endmodule

bind elevation_color_ramp ecr_checker u_ecr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .red          (red),
    .green        (green),
    .blue         (blue)
);

`default_nettype wire
